// ----- rtl/hft_pkg.sv -----
// Shared types and fixed constants of the Hilbert transformer.
`timescale 1ns / 1ps

package hft_pkg;

	// Coefficient format: signed Q1.15
	localparam int TAP_WIDTH = 16;
	localparam int FRAC_BITS = 15;

	// Q30 constants for building the windowed taps
	localparam longint Q30_ONE = longint'(1) << 30;
	localparam longint PI_Q30 = 64'sd3373259426;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // write the new sample, clear the accumulator
		logic issue;  // read one tap pair and start its product
		logic finish; // round, saturate and load the output register
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last_issue; // the tap pair being issued is the final one
	} status_t;

endpackage

// ----- rtl/hilbert_fir_filter.sv -----
// Top level of the streaming Hilbert transformer.
`timescale 1ns / 1ps

// Hilbert transformer, 2*HALF_LENGTH+1 taps with a Hann window, one quadrature
// beat out for each sample beat in, delayed by HALF_LENGTH samples. Samples and
// results are signed Q1.15 (SAMPLE_WIDTH bits); the sum is rounded half up and
// saturated. The taps are odd-symmetric, so each cycle one two-port read of the
// delay line memory yields a pair of samples whose difference goes through a
// single multiplier. For each sample the controller accepts it, issues one tap
// pair per cycle, passes the drain states DRAIN1 and DRAIN2, then rounds and
// loads the output register once that register is free. A finished result
// waits in the output register while the next sample is accepted.
// After reset no clearing pass is needed: a fill count makes unwritten delay
// line entries read as zero.
module hilbert_fir_filter #(
	parameter int HALF_LENGTH  = 63,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                           quadrature_valid,
	input  logic                           quadrature_stall,
	output logic signed [SAMPLE_WIDTH-1:0] quadrature
);

	hft_pkg::cmd_t    cmd;
	hft_pkg::status_t status;

	hft_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_stall     (sample_stall),
		.quadrature_valid (quadrature_valid),
		.quadrature_stall (quadrature_stall),
		.cmd              (cmd),
		.status           (status)
	);

	hft_datapath #(
		.HalfLength  (HALF_LENGTH),
		.SampleWidth (SAMPLE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample     (sample),
		.quadrature (quadrature)
	);

endmodule

// ----- rtl/hft_ctrl.sv -----
// Sequencer for one sample: accept, walk the tap pairs, drain, deliver.
`timescale 1ns / 1ps

module hft_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_stall,
	output logic            quadrature_valid,
	input  logic            quadrature_stall,
	output hft_pkg::cmd_t   cmd,
	input  hft_pkg::status_t status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_free;

	// Output register can take a new beat when empty or being drained now
	assign out_free = !quadrature_valid || !quadrature_stall;

	assign sample_stall = (state_q != ST_IDLE);

	// Decode commands from the state
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && sample_valid;
		cmd.issue  = (state_q == ST_RUN);
		cmd.finish = (state_q == ST_FINISH) && out_free;
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			quadrature_valid <= 1'b0;
		end else begin
			if (quadrature_valid && !quadrature_stall && !cmd.finish) begin
				quadrature_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (status.last_issue) begin
						state_q <= ST_DRAIN1;
					end
				end
				ST_DRAIN1: begin
					state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						quadrature_valid <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/hft_datapath.sv -----
// Delay line memory, tap table and multiply-accumulate datapath.
`timescale 1ns / 1ps

module hft_datapath #(
	parameter int HalfLength  = 63,
	parameter int SampleWidth = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hft_pkg::cmd_t                 cmd,
	output hft_pkg::status_t              status,
	input  logic signed [SampleWidth-1:0] sample,
	output logic signed [SampleWidth-1:0] quadrature
);

	localparam int TapW     = hft_pkg::TAP_WIDTH;
	localparam int TapCount = 2 * HalfLength + 1;
	localparam int NumTaps  = (HalfLength + 1) / 2;
	localparam int IdxW     = (NumTaps > 1) ? $clog2(NumTaps) : 1;
	localparam int PtrW     = $clog2(TapCount);
	localparam int CntW     = $clog2(TapCount + 1);
	localparam int ProdW    = SampleWidth + 1 + TapW;
	localparam int AccW     = ProdW + $clog2(NumTaps + 1);
	localparam int Frac     = hft_pkg::FRAC_BITS;

	localparam logic [PtrW:0] HalfK   = (PtrW + 1)'(HalfLength);
	localparam logic [PtrW:0] CountK  = (PtrW + 1)'(TapCount);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(TapCount - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(TapCount);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NumTaps - 1);

	localparam logic signed [AccW:0] RoundBias = (AccW + 1)'(longint'(1) << (Frac - 1));
	localparam logic signed [AccW:0] SatMax =
		(AccW + 1)'((longint'(1) << (SampleWidth - 1)) - 1);
	localparam logic signed [AccW:0] SatMin = -SatMax - (AccW + 1)'(1);

	// Windowed taps for odd offsets m = 2j+1, positive side
	logic signed [TapW-1:0] tap_tbl [NumTaps];

	for (genvar j = 0; j < NumTaps; j++) begin : g_tap
		localparam longint Mag = 2 * longint'(j) + 1;
		localparam longint One = hft_pkg::Q30_ONE;
		localparam longint Ang = (hft_pkg::PI_Q30 * Mag) / (2 * longint'(HalfLength));
		localparam longint Ang2 = (Ang * Ang) / One;
		localparam longint T7 = One - ((Ang2 * One) / One) / (13 * 14);
		localparam longint T6 = One - ((Ang2 * T7) / One) / (11 * 12);
		localparam longint T5 = One - ((Ang2 * T6) / One) / (9 * 10);
		localparam longint T4 = One - ((Ang2 * T5) / One) / (7 * 8);
		localparam longint T3 = One - ((Ang2 * T4) / One) / (5 * 6);
		localparam longint T2 = One - ((Ang2 * T3) / One) / (3 * 4);
		localparam longint T1 = One - ((Ang2 * T2) / One) / (1 * 2);
		localparam longint Cos = (T1 < 0) ? 0 : T1;
		localparam longint Win = (Cos * Cos) / One;
		localparam longint Den = hft_pkg::PI_Q30 * Mag;
		localparam longint Val = (2 * Win * (longint'(1) << Frac) + Den / 2) / Den;
		assign tap_tbl[j] = TapW'(Val);
	end

	// Delay line storage, circular, newest sample at wp_q
	logic signed [SampleWidth-1:0] mem [TapCount];

	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] wp_next;
	logic [CntW-1:0] fill_q;
	logic [IdxW-1:0] idx_q;
	logic            issue_s1;
	logic            issue_s2;

	logic [PtrW:0]   m_off;
	logic [PtrW:0]   pos_a;
	logic [PtrW:0]   pos_b;
	logic [PtrW:0]   wp_ext;
	logic [PtrW:0]   fill_ext;
	logic [PtrW:0]   addr_a_w;
	logic [PtrW:0]   addr_b_w;
	logic [PtrW-1:0] addr_a;
	logic [PtrW-1:0] addr_b;
	logic            va;
	logic            vb;

	logic signed [SampleWidth-1:0] rd_a_s1;
	logic signed [SampleWidth-1:0] rd_b_s1;
	logic                          va_s1;
	logic                          vb_s1;
	logic signed [TapW-1:0]        tap_s1;
	logic signed [SampleWidth:0]   diff;
	logic signed [ProdW-1:0]       prod_s2;
	logic signed [AccW-1:0]        acc_q;
	logic signed [AccW:0]          rounded;
	logic signed [AccW:0]          shifted;
	logic signed [SampleWidth-1:0] sat;

	assign wp_next = (wp_q == LastPtr) ? '0 : wp_q + PtrW'(1);

	// Positions of the pair: older at M+m, newer at M-m
	always_comb begin
		m_off    = (PtrW + 1)'({idx_q, 1'b1});
		pos_a    = HalfK + m_off;
		pos_b    = HalfK - m_off;
		wp_ext   = {1'b0, wp_q};
		fill_ext = (PtrW + 1)'(fill_q);
		addr_a_w = (wp_ext >= pos_a) ? (wp_ext - pos_a) : (wp_ext + CountK - pos_a);
		addr_b_w = (wp_ext >= pos_b) ? (wp_ext - pos_b) : (wp_ext + CountK - pos_b);
		addr_a   = addr_a_w[PtrW-1:0];
		addr_b   = addr_b_w[PtrW-1:0];
		va       = (pos_a < fill_ext);
		vb       = (pos_b < fill_ext);
	end

	assign status.last_issue = (idx_q == LastIdx);

	// Write the new sample; read both members of the pair
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[wp_next] <= sample;
		end
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
	end

	// Advance pointer, fill count, tap index and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			issue_s1 <= 1'b0;
			issue_s2 <= 1'b0;
		end else begin
			issue_s1 <= cmd.issue;
			issue_s2 <= issue_s1;
			if (cmd.load) begin
				wp_q  <= wp_next;
				idx_q <= '0;
				if (fill_q != FullCnt) begin
					fill_q <= fill_q + CntW'(1);
				end
			end else if (cmd.issue && !status.last_issue) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	// Difference of the pair: unwritten entries read as zero
	assign diff = (va_s1 ? (SampleWidth + 1)'(rd_a_s1) : '0)
	            - (vb_s1 ? (SampleWidth + 1)'(rd_b_s1) : '0);

	// Multiply and accumulate
	always_ff @(posedge clk) begin
		va_s1   <= va;
		vb_s1   <= vb;
		tap_s1  <= tap_tbl[idx_q];
		prod_s2 <= diff * tap_s1;
		if (cmd.load) begin
			acc_q <= '0;
		end else if (issue_s2) begin
			acc_q <= acc_q + AccW'(prod_s2);
		end
	end

	// Round half up, then saturate to the sample range
	always_comb begin
		rounded = (AccW + 1)'(acc_q) + RoundBias;
		shifted = rounded >>> Frac;
		if (shifted > SatMax) begin
			sat = SampleWidth'(SatMax);
		end else if (shifted < SatMin) begin
			sat = SampleWidth'(SatMin);
		end else begin
			sat = SampleWidth'(shifted);
		end
	end

	// Hold the result beat
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			quadrature <= sat;
		end
	end

endmodule
